// File: hw/rtl/swk_pkg.sv
// shared constants, widths and the arctangent table for the swerve angle block
// no dependencies
`default_nettype none

package swk_pkg;

  // datapath widths
  localparam int STICK_W = 16;
  localparam int ANGLE_W = 15;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int CW      = 52;  // cordic x/y width, covers 2^48 inputs with gain 1.65
  localparam int ZW      = 26;  // angle accumulator in 2^-16 degree

  // register indexes
  localparam logic [IDX_W-1:0] REG_DEADBAND  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROT_GAIN  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HALF_WB   = 2'd2;
  localparam logic [IDX_W-1:0] REG_HALF_TW   = 2'd3;

  // register reset values
  localparam logic [14:0] RST_DEADBAND = 15'd3277;
  localparam logic [15:0] RST_ROT_GAIN = 16'd819;
  localparam logic [15:0] RST_HALF_WB  = 16'd256;
  localparam logic [15:0] RST_HALF_TW  = 16'd256;

  // cordic constants
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int TABLE_LEN         = 24;
  localparam logic signed [ZW-1:0] ANGLE_90  = 26'sd5898240;
  localparam logic signed [ZW-1:0] OUT_LIMIT = 26'sd11520;
  localparam logic signed [ZW-1:0] ROUND_ADD = 26'sd512;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic signed [ZW-1:0] atan_value(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/swerve_module_angle_kinematics.sv
// swerve module steering angles: deadband, wheel vectors and four cordic atan2 pipelines
// depends on swk_pkg
`default_nettype none

// One transaction of three stick axes gives one transaction of four steering angles in
// 1/64 degree. The pipeline takes a new transaction every cycle while the output is not
// stalled. It has five front stages (deadband, two multiplies, vector sums, quadrant fold),
// one cordic stage per iteration and the rounding/output register. A stall on the output
// freezes the whole pipeline, so in_ready follows out_ready while the output register is
// full. Registers must be written by the user through the cfg port only while no transaction
// is in flight; the block itself does not enforce this.
module swerve_module_angle_kinematics
  import swk_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_write,
  input  wire [IDX_W-1:0]           cfg_index,
  input  wire [CFG_W-1:0]           cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire signed [STICK_W-1:0]  rotate_stick,
  input  wire signed [STICK_W-1:0]  strafe_stick,
  input  wire signed [STICK_W-1:0]  forward_stick,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [ANGLE_W-1:0] front_left_angle,
  output logic signed [ANGLE_W-1:0] front_right_angle,
  output logic signed [ANGLE_W-1:0] back_left_angle,
  output logic signed [ANGLE_W-1:0] back_right_angle
);

  localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // configuration registers
  logic [14:0] deadband;
  logic [15:0] rot_gain;
  logic [15:0] half_wb;
  logic [15:0] half_tw;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= RST_DEADBAND;
      rot_gain <= RST_ROT_GAIN;
      half_wb  <= RST_HALF_WB;
      half_tw  <= RST_HALF_TW;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEADBAND: deadband <= cfg_data[14:0];
        REG_ROT_GAIN: rot_gain <= cfg_data;
        REG_HALF_WB:  half_wb  <= cfg_data;
        REG_HALF_TW:  half_tw  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: whole pipeline moves unless the output is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // deadband
  function automatic logic signed [STICK_W-1:0] dead(input logic signed [STICK_W-1:0] v,
                                                     input logic [14:0] thr);
    logic [STICK_W:0] mag;
    mag = v[STICK_W-1] ? (17'd0 - {v[STICK_W-1], v}) : {1'b0, v};
    return (mag < {2'b00, thr}) ? '0 : v;
  endfunction

  // stage 1: deadband applied
  logic                      v1;
  logic signed [STICK_W-1:0] rot1, sx1, fy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      rot1 <= dead(rotate_stick, deadband);
      sx1  <= dead(strafe_stick, deadband);
      fy1  <= dead(forward_stick, deadband);
    end
  end

  // stage 2: angular rate
  logic                      v2;
  logic signed [32:0]        rate2;
  logic signed [STICK_W-1:0] sx2, fy2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      rate2 <= rot1 * $signed({1'b0, rot_gain});
      sx2   <= sx1;
      fy2   <= fy1;
    end
  end

  // stage 3: rate times half wheelbase and half trackwidth
  logic                      v3;
  logic signed [49:0]        tb3, tt3;
  logic signed [STICK_W-1:0] sx3, fy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      tb3 <= rate2 * $signed({1'b0, half_wb});
      tt3 <= rate2 * $signed({1'b0, half_tw});
      sx3 <= sx2;
      fy3 <= fy2;
    end
  end

  // stage 4: wheel vector components
  logic                 v4;
  logic signed [CW-1:0] a4, b4, c4, d4;
  logic signed [CW-1:0] xq, yq, tbe, tte;

  assign xq  = {{(CW-36){sx3[STICK_W-1]}}, sx3, 20'd0};
  assign yq  = {{(CW-36){fy3[STICK_W-1]}}, fy3, 20'd0};
  assign tbe = {{(CW-50){tb3[49]}}, tb3};
  assign tte = {{(CW-50){tt3[49]}}, tt3};

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      a4 <= xq - tbe;
      b4 <= xq + tbe;
      c4 <= yq - tte;
      d4 <= yq + tte;
    end
  end

  // lane inputs: fl (c,a), fr (d,a), bl (c,b), br (d,b)
  logic signed [CW-1:0] lane_x [0:3];
  logic signed [CW-1:0] lane_y [0:3];
  assign lane_x[0] = a4; assign lane_y[0] = c4;
  assign lane_x[1] = a4; assign lane_y[1] = d4;
  assign lane_x[2] = b4; assign lane_y[2] = c4;
  assign lane_x[3] = b4; assign lane_y[3] = d4;

  // cordic pipeline: index 0 is the quadrant fold, index k after k iterations
  logic                 cv [0:NS];
  logic signed [CW-1:0] cx [0:NS][0:3];
  logic signed [CW-1:0] cy [0:NS][0:3];
  logic signed [ZW-1:0] cz [0:NS][0:3];
  logic                 cnul [0:NS][0:3];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= v4;
  end

  genvar g, s;
  generate
    for (g = 0; g < 4; g++) begin : g_fold
      // fold the left half plane by +-90 degrees
      always_ff @(posedge clk) begin
        if (adv) begin
          cnul[0][g] <= (lane_x[g] == '0) && (lane_y[g] == '0);
          if (lane_x[g][CW-1] && !lane_y[g][CW-1]) begin
            cx[0][g] <= lane_y[g];
            cy[0][g] <= -lane_x[g];
            cz[0][g] <= ANGLE_90;
          end else if (lane_x[g][CW-1]) begin
            cx[0][g] <= -lane_y[g];
            cy[0][g] <= lane_x[g];
            cz[0][g] <= -ANGLE_90;
          end else begin
            cx[0][g] <= lane_x[g];
            cy[0][g] <= lane_y[g];
            cz[0][g] <= '0;
          end
        end
      end
    end

    for (s = 0; s < NS; s++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) cv[s+1] <= 1'b0;
        else if (adv) cv[s+1] <= cv[s];
      end
      for (g = 0; g < 4; g++) begin : g_lane
        // one vectoring iteration
        always_ff @(posedge clk) begin
          if (adv) begin
            cnul[s+1][g] <= cnul[s][g];
            if (!cy[s][g][CW-1]) begin
              cx[s+1][g] <= cx[s][g] + (cy[s][g] >>> s);
              cy[s+1][g] <= cy[s][g] - (cx[s][g] >>> s);
              cz[s+1][g] <= cz[s][g] + atan_value(s);
            end else begin
              cx[s+1][g] <= cx[s][g] - (cy[s][g] >>> s);
              cy[s+1][g] <= cy[s][g] + (cx[s][g] >>> s);
              cz[s+1][g] <= cz[s][g] - atan_value(s);
            end
          end
        end
      end
    end
  endgenerate

  // rounding to 1/64 degree and saturation, zero angle for a zero vector
  function automatic logic signed [ANGLE_W-1:0] finish(input logic signed [ZW-1:0] z,
                                                       input logic nul);
    logic signed [ZW-1:0] r;
    r = (z + ROUND_ADD) >>> 10;
    if (nul) r = '0;
    else if (r > OUT_LIMIT) r = OUT_LIMIT;
    else if (r < -OUT_LIMIT) r = -OUT_LIMIT;
    return r[ANGLE_W-1:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= cv[NS];
    if (adv) begin
      front_left_angle  <= finish(cz[NS][0], cnul[NS][0]);
      front_right_angle <= finish(cz[NS][1], cnul[NS][1]);
      back_left_angle   <= finish(cz[NS][2], cnul[NS][2]);
      back_right_angle  <= finish(cz[NS][3], cnul[NS][3]);
    end
  end

  // checks
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(cv[NS]) && $stable(v4))
    else $error("pipeline valid moved during stall");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    adv && cv[NS] && cnul[NS][0] |=> front_left_angle == '0)
    else $error("zero vector did not give zero angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (front_left_angle <= 15'sd11520) && (front_left_angle >= -15'sd11520)
               && (back_right_angle <= 15'sd11520) && (back_right_angle >= -15'sd11520))
    else $error("angle out of range");

  a_feed: assert property (@(posedge clk) disable iff (rst)
    adv && cv[NS] |=> out_valid)
    else $error("finished transaction lost at output");

endmodule

`default_nettype wire

// File: verif/swerve_module_angle_kinematics_tb.sv
// testbench for the swerve module steering angle block: random and directed stick transactions
// checked against a fixed-point cordic atan2 predictor; depends on swk_pkg and the block rtl
`timescale 1ns / 1ps

module swerve_module_angle_kinematics_tb;
  import swk_pkg::*;

  localparam int STAGES = DEF_CORDIC_STAGES;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic signed [STICK_W-1:0] rot;
    logic signed [STICK_W-1:0] sx;
    logic signed [STICK_W-1:0] fy;
  } sticks_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] fl;
    logic signed [ANGLE_W-1:0] fr;
    logic signed [ANGLE_W-1:0] bl;
    logic signed [ANGLE_W-1:0] br;
  } angles_t;

  logic clk, rst;
  logic cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [STICK_W-1:0] rotate_stick, strafe_stick, forward_stick;
  logic signed [ANGLE_W-1:0] front_left_angle, front_right_angle;
  logic signed [ANGLE_W-1:0] back_left_angle, back_right_angle;

  sticks_t pending_sticks[$];
  angles_t expected_angles[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_phase = 0;
  bit hold_sender = 0;
  bit in_taken = 0;

  // predictor copy of the registers
  longint db_thr = 3277, rot_gain = 819, half_wb = 256, half_tw = 256;

  swerve_module_angle_kinematics u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .rotate_stick(rotate_stick), .strafe_stick(strafe_stick),
    .forward_stick(forward_stick),
    .out_valid(out_valid), .out_ready(out_ready),
    .front_left_angle(front_left_angle), .front_right_angle(front_right_angle),
    .back_left_angle(back_left_angle), .back_right_angle(back_right_angle)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // floor shift of a signed value
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint gate_deadband(longint v);
    longint mag;
    mag = v < 0 ? -v : v;
    return (mag < db_thr) ? 0 : v;
  endfunction

  // atan2 by cordic vectoring, 1/64 degree result
  function automatic logic signed [ANGLE_W-1:0] steer_angle(longint y, longint x);
    longint z, t, xs, ys;
    int n;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 5898240;
      end else begin
        t = x; x = -y; y = t; z = -5898240;
      end
    end
    n = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
    for (int i = 0; i < n; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(atan_value(i));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(atan_value(i));
      end
    end
    z = floor_shift(z + 512, 10);
    if (z > 11520) z = 11520;
    if (z < -11520) z = -11520;
    return z[ANGLE_W-1:0];
  endfunction

  function automatic angles_t predict_angles(sticks_t s);
    longint r, x, y, rate, tb, tt, a, b, c, d;
    angles_t o;
    r = gate_deadband(longint'(s.rot));
    x = gate_deadband(longint'(s.sx));
    y = gate_deadband(longint'(s.fy));
    rate = r * rot_gain;
    tb = rate * half_wb;
    tt = rate * half_tw;
    a = x * 1048576 - tb;
    b = x * 1048576 + tb;
    c = y * 1048576 - tt;
    d = y * 1048576 + tt;
    o.fl = steer_angle(c, a);
    o.fr = steer_angle(d, a);
    o.bl = steer_angle(c, b);
    o.br = steer_angle(d, b);
    return o;
  endfunction

  // driver: offers the next pending transaction, idles now and then
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) begin
        void'(pending_sticks.pop_front());
      end
      if (pending_sticks.size() != 0 && !hold_sender &&
          (quiet_phase || $urandom_range(99) >= 11)) begin
        in_valid <= 1'b1;
        rotate_stick <= pending_sticks[0].rot;
        strafe_stick <= pending_sticks[0].sx;
        forward_stick <= pending_sticks[0].fy;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst ? 1'b0 : (quiet_phase || $urandom_range(99) >= 11);
  end

  // accepted input transactions feed the predictor
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_angles.push_back(predict_angles(pending_sticks[0]));
    end
  end

  // monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    angles_t want, got;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      got = '{front_left_angle, front_right_angle, back_left_angle, back_right_angle};
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_angles.pop_front();
        if (got.fl !== want.fl) begin
          $display("%0t: front_left expected %0d actual %0d", $time, want.fl, got.fl);
          errors++;
        end
        if (got.fr !== want.fr) begin
          $display("%0t: front_right expected %0d actual %0d", $time, want.fr, got.fr);
          errors++;
        end
        if (got.bl !== want.bl) begin
          $display("%0t: back_left expected %0d actual %0d", $time, want.bl, got.bl);
          errors++;
        end
        if (got.br !== want.br) begin
          $display("%0t: back_right expected %0d actual %0d", $time, want.br, got.br);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("** swerve_module_angle_kinematics: FAILED **");
      $finish;
    end
  end

  // register write while the pipeline is empty
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_DEADBAND: db_thr = val[14:0];
      REG_ROT_GAIN: rot_gain = val;
      REG_HALF_WB:  half_wb = val;
      default:      half_tw = val;
    endcase
  endtask

  task automatic drain_pipeline();
    wait (pending_sticks.size() == 0 && !in_valid && expected_angles.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [STICK_W-1:0] pick_stick();
    int v;
    case ($urandom_range(7))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3: v = int'($urandom_range(200)) - 100;
      4: v = int'(db_thr) - 1;
      5: v = -int'(db_thr);
      default: v = int'($urandom());
    endcase
    return v[STICK_W-1:0];
  endfunction

  task automatic queue_random(int n);
    sticks_t s;
    for (int i = 0; i < n; i++) begin
      s.rot = pick_stick();
      s.sx = pick_stick();
      s.fy = pick_stick();
      pending_sticks.push_back(s);
    end
  endtask

  // stimulus
  initial begin
    sticks_t s;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    rotate_stick = '0;
    strafe_stick = '0;
    forward_stick = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero vector, pure axes, extremes, deadband edges
    pending_sticks.push_back('{16'sd0, 16'sd0, 16'sd0});
    pending_sticks.push_back('{16'sd0, -16'sd32768, 16'sd0});
    pending_sticks.push_back('{16'sd0, 16'sd32767, 16'sd0});
    pending_sticks.push_back('{16'sd0, 16'sd0, 16'sd32767});
    pending_sticks.push_back('{16'sd0, 16'sd0, -16'sd32768});
    pending_sticks.push_back('{16'sd32767, 16'sd0, 16'sd0});
    pending_sticks.push_back('{-16'sd32768, 16'sd0, 16'sd0});
    pending_sticks.push_back('{16'sd3276, 16'sd3277, -16'sd3277});
    pending_sticks.push_back('{-16'sd3276, -16'sd3276, 16'sd3276});
    pending_sticks.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    pending_sticks.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
    pending_sticks.push_back('{16'sd5000, -16'sd20000, 16'sd12000});
    pending_sticks.push_back('{16'shffff, 16'sh5555, 16'shaaaa});
    drain_pipeline();

    // extreme register settings
    write_reg(REG_DEADBAND, 16'hffff);
    write_reg(REG_ROT_GAIN, 16'hffff);
    write_reg(REG_HALF_WB, 16'hffff);
    write_reg(REG_HALF_TW, 16'hffff);
    queue_random(300);
    drain_pipeline();

    write_reg(REG_DEADBAND, 16'd0);
    write_reg(REG_ROT_GAIN, 16'd0);
    write_reg(REG_HALF_WB, 16'd0);
    write_reg(REG_HALF_TW, 16'd1);
    queue_random(300);

    // sender holds off until everything has come back
    wait (pending_sticks.size() <= 150);
    hold_sender = 1'b1;
    wait (expected_angles.size() == 0 && !in_valid);
    hold_sender = 1'b0;
    drain_pipeline();

    // long stretch without idling
    write_reg(REG_DEADBAND, 16'd3277);
    write_reg(REG_ROT_GAIN, 16'd819);
    write_reg(REG_HALF_WB, 16'd256);
    write_reg(REG_HALF_TW, 16'd256);
    quiet_phase = 1'b1;
    queue_random(400);
    drain_pipeline();
    quiet_phase = 1'b0;

    // random register settings
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_DEADBAND, CFG_W'($urandom()));
      write_reg(REG_ROT_GAIN, CFG_W'($urandom()));
      write_reg(REG_HALF_WB, CFG_W'($urandom()));
      write_reg(REG_HALF_TW, CFG_W'($urandom()));
      queue_random(230);
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("** swerve_module_angle_kinematics: PASSED **");
    end else begin
      $display("** swerve_module_angle_kinematics: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/swk_pkg.sv
hw/rtl/swerve_module_angle_kinematics.sv
verif/swerve_module_angle_kinematics_tb.sv
